### hdl/ssefp_pkg.sv
// types, constants and per-byte step functions for the sse stream field parser
// used by ssefp_res_queue and sse_stream_field_parser_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ssefp_pkg;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_NAME   = 3'd1;
    localparam logic [2:0] PH_VSTART = 3'd2;
    localparam logic [2:0] PH_VALUE  = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;

    localparam int unsigned M_DATA_BIT  = 0;
    localparam int unsigned M_ID_BIT    = 1;
    localparam int unsigned M_EVENT_BIT = 2;
    localparam int unsigned M_RETRY_BIT = 3;

    localparam logic [1:0] NM_DATA  = 2'd0;
    localparam logic [1:0] NM_ID    = 2'd1;
    localparam logic [1:0] NM_EVENT = 2'd2;
    localparam logic [1:0] NM_RETRY = 2'd3;

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_RETRY = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [1:0] TAG_DATA  = 2'd0;
    localparam logic [1:0] TAG_ID    = 2'd1;
    localparam logic [1:0] TAG_EVENT = 2'd2;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [2:0] NAME_LEN_MAX = 3'd7;

    typedef struct packed {
        logic [2:0]  line_phase;
        logic [3:0]  name_match;
        logic [2:0]  name_length;
        logic        cr_held;
        logic        has_field;
        logic        data_nonempty;
        logic [30:0] retry_accum;
        logic        retry_minus;
        logic        retry_digit_seen;
        logic        retry_invalid;
    } t_state;

    localparam t_state C_STATE_RST = '{
        line_phase:       PH_START,
        name_match:       4'hF,
        name_length:      3'd0,
        cr_held:          1'b0,
        has_field:        1'b0,
        data_nonempty:    1'b0,
        retry_accum:      31'd0,
        retry_minus:      1'b0,
        retry_digit_seen: 1'b0,
        retry_invalid:    1'b0
    };

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  field_tag;
        logic [7:0]  value_byte;
        logic [30:0] retry_delay;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        t_state  s;
        logic    emit;
        t_result r;
    } t_ord;

    // results of one accepted byte, toward the result queue
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        t_state s;
        t_push  push;
    } t_step;

    function automatic logic [2:0] f_name_len(input logic [1:0] idx);
        logic [2:0] len;
        case (idx)
            NM_DATA:  len = 3'd4;
            NM_ID:    len = 3'd2;
            NM_EVENT: len = 3'd5;
            NM_RETRY: len = 3'd5;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] f_name_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            NM_DATA: begin
                case (pos)
                    3'd0:    ch = 8'h64;
                    3'd1:    ch = 8'h61;
                    3'd2:    ch = 8'h74;
                    3'd3:    ch = 8'h61;
                    default: ch = 8'h00;
                endcase
            end
            NM_ID: begin
                case (pos)
                    3'd0:    ch = 8'h69;
                    3'd1:    ch = 8'h64;
                    default: ch = 8'h00;
                endcase
            end
            NM_EVENT: begin
                case (pos)
                    3'd0:    ch = 8'h65;
                    3'd1:    ch = 8'h76;
                    3'd2:    ch = 8'h65;
                    3'd3:    ch = 8'h6E;
                    3'd4:    ch = 8'h74;
                    default: ch = 8'h00;
                endcase
            end
            NM_RETRY: begin
                case (pos)
                    3'd0:    ch = 8'h72;
                    3'd1:    ch = 8'h65;
                    3'd2:    ch = 8'h74;
                    3'd3:    ch = 8'h72;
                    3'd4:    ch = 8'h79;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] f_resolved(input t_state s);
        logic [3:0] m;
        m = 4'h0;
        for (int i = 0; i < 4; i++) begin
            if (s.name_match[i] && s.name_length == f_name_len(2'(i))) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic t_result f_res(input logic [1:0] kind, input logic [1:0] tag,
                                      input logic [7:0] vb, input logic [30:0] ms);
        t_result r;
        r.result_kind = kind;
        r.field_tag   = tag;
        r.value_byte  = vb;
        r.retry_delay = ms;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // actions when a recognized name ends
    function automatic t_ord f_name_done(input t_state s, input logic [3:0] m);
        t_ord o;
        o.s    = s;
        o.emit = 1'b0;
        o.r    = '0;
        if (m[M_DATA_BIT]) begin
            o.s.has_field = 1'b1;
            if (s.data_nonempty) begin
                o.emit = 1'b1;
                o.r    = f_res(KIND_VALUE, TAG_DATA, CH_LF, 31'd0);
            end
        end else if (m[M_ID_BIT]) begin
            o.s.has_field = 1'b1;
            o.emit        = 1'b1;
            o.r           = f_res(KIND_CLEAR, TAG_ID, 8'h00, 31'd0);
        end else if (m[M_EVENT_BIT]) begin
            o.s.has_field = 1'b1;
            o.emit        = 1'b1;
            o.r           = f_res(KIND_CLEAR, TAG_EVENT, 8'h00, 31'd0);
        end
        return o;
    endfunction

    function automatic t_state f_line_init(input t_state s);
        t_state n;
        n               = C_STATE_RST;
        n.has_field     = s.has_field;
        n.data_nonempty = s.data_nonempty;
        return n;
    endfunction

    // one byte other than line feed
    function automatic t_ord f_ordinary(input t_state s, input logic [7:0] c);
        t_ord        o;
        logic [2:0]  ph;
        logic [3:0]  m;
        logic [34:0] v;
        logic        stop;
        o    = '0;
        o.s  = s;
        ph   = s.line_phase;
        m    = 4'h0;
        v    = '0;
        stop = 1'b0;
        if (ph == PH_START) begin
            if (c == CH_COLON) begin
                o.s.line_phase = PH_SKIP;
                stop           = 1'b1;
            end else begin
                ph = PH_NAME;
            end
        end
        if (!stop && ph == PH_NAME) begin
            stop = 1'b1;
            if (c == CH_COLON) begin
                m              = f_resolved(s);
                o.s.name_match = m;
                if (m == 4'h0) begin
                    o.s.line_phase = PH_SKIP;
                end else begin
                    o.s.line_phase = PH_VSTART;
                    o              = f_name_done(o.s, m);
                end
            end else begin
                o.s.line_phase = PH_NAME;
                for (int i = 0; i < 4; i++) begin
                    if (!(s.name_length < f_name_len(2'(i)) &&
                          f_name_char(2'(i), s.name_length) == c)) begin
                        o.s.name_match[i] = 1'b0;
                    end
                end
                if (s.name_length < NAME_LEN_MAX) begin
                    o.s.name_length = s.name_length + 3'd1;
                end
            end
        end
        if (!stop && ph == PH_VSTART) begin
            o.s.line_phase = PH_VALUE;
            ph             = PH_VALUE;
            if (c == CH_SPACE) begin
                stop = 1'b1;
            end
        end
        if (!stop && ph == PH_VALUE) begin
            if (s.name_match[M_RETRY_BIT]) begin
                if (!s.retry_invalid) begin
                    if (c == CH_MINUS && !s.retry_minus && !s.retry_digit_seen) begin
                        o.s.retry_minus = 1'b1;
                    end else if (c inside {[CH_0:CH_9]}) begin
                        v = ({4'b0, s.retry_accum} << 3) + ({4'b0, s.retry_accum} << 1)
                            + {31'b0, c[3:0]};
                        o.s.retry_digit_seen = 1'b1;
                        if (v[34:31] != 4'h0) begin
                            o.s.retry_invalid = 1'b1;
                        end else begin
                            o.s.retry_accum = v[30:0];
                        end
                    end else begin
                        o.s.retry_invalid = 1'b1;
                    end
                end
            end else if (s.name_match[M_DATA_BIT]) begin
                o.s.data_nonempty = 1'b1;
                o.emit            = 1'b1;
                o.r               = f_res(KIND_VALUE, TAG_DATA, c, 31'd0);
            end else if (s.name_match[M_ID_BIT]) begin
                o.emit = 1'b1;
                o.r    = f_res(KIND_VALUE, TAG_ID, c, 31'd0);
            end else if (s.name_match[M_EVENT_BIT]) begin
                o.emit = 1'b1;
                o.r    = f_res(KIND_VALUE, TAG_EVENT, c, 31'd0);
            end
        end
        return o;
    endfunction

    function automatic t_ord f_end_line(input t_state s);
        t_ord o;
        o   = '0;
        o.s = s;
        case (s.line_phase)
            PH_START: begin
                if (s.has_field) begin
                    o.emit            = 1'b1;
                    o.r               = f_res(KIND_END, TAG_DATA, 8'h00, 31'd0);
                    o.s.has_field     = 1'b0;
                    o.s.data_nonempty = 1'b0;
                end
            end
            PH_NAME: begin
                o = f_name_done(s, f_resolved(s));
            end
            PH_VSTART, PH_VALUE: begin
                if (s.name_match[M_RETRY_BIT] && !s.retry_invalid && s.retry_digit_seen &&
                    (!s.retry_minus || s.retry_accum == 31'd0)) begin
                    o.s.has_field = 1'b1;
                    o.emit        = 1'b1;
                    o.r           = f_res(KIND_RETRY, TAG_DATA, 8'h00, s.retry_accum);
                end
            end
            default: begin
            end
        endcase
        o.s = f_line_init(o.s);
        return o;
    endfunction

    // full work for one stream byte
    function automatic t_step f_step(input t_state s, input logic [7:0] c);
        t_step  st;
        t_ord   o1;
        t_ord   o2;
        t_state cur;
        st  = '0;
        o1  = '0;
        o2  = '0;
        cur = s;
        if (c == CH_LF) begin
            o2  = f_end_line(s);
            cur = o2.s;
        end else begin
            if (s.cr_held) begin
                cur.cr_held = 1'b0;
                o1          = f_ordinary(cur, CH_CR);
                cur         = o1.s;
            end
            if (c == CH_CR) begin
                if (cur.line_phase != PH_SKIP) begin
                    cur.cr_held = 1'b1;
                end
            end else begin
                o2  = f_ordinary(cur, c);
                cur = o2.s;
            end
        end
        st.s        = cur;
        st.push.cnt = {1'b0, o1.emit} + {1'b0, o2.emit};
        if (o1.emit) begin
            st.push.r0 = o1.r;
            st.push.r1 = o2.r;
        end else begin
            st.push.r0 = o2.r;
            st.push.r1 = '0;
        end
        if (st.push.cnt == 2'd2) begin
            st.push.r1.last_of_run = 1'b1;
        end else begin
            st.push.r0.last_of_run = 1'b1;
        end
        return st;
    endfunction

endpackage

`default_nettype wire

### hdl/ssefp_res_queue.sv
// four-entry result queue: takes up to two results per cycle, hands out one
// depends on ssefp_pkg for the result and push types
`timescale 1ns / 1ps
`default_nettype none

module ssefp_res_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire ssefp_pkg::t_push   i_push,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire                     i_pop,
    output ssefp_pkg::t_result      o_res
);
    import ssefp_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_count;
    logic [1:0] n_wp;
    logic [1:0] n_rp;
    logic [2:0] n_count;
    logic       w_pop;

    assign o_room  = r_count < 3'd3;
    assign o_valid = r_count != 3'd0;
    assign o_res   = r_mem[r_rp];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wp    = r_wp + i_push.cnt;
        n_rp    = r_rp + {1'b0, w_pop};
        n_count = r_count + {1'b0, i_push.cnt} - {2'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 2'd0;
            r_rp    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_push.r1;
        end
    end

endmodule

`default_nettype wire

### hdl/sse_stream_field_parser_core.sv
// top level of the sse stream field parser: line state register and result queue
// depends on ssefp_pkg and ssefp_res_queue
//
// channel   dir  tdata                                    tuser              tlast
// s (in)    in   [7:0] stream_byte                        -                  -
// m (out)   out  [7:0] value_byte, [38:8] retry_delay    [1:0] result_kind  last_of_run
//                                                         [3:2] field_tag
//
// one byte per cycle; the byte is decoded against the line state register in the
// accepting cycle and its zero to two results are written into a four-entry queue
// results leave one per cycle while m tready is high, so bytes giving two results slow the input to the
// output rate; s tready drops while fewer than two queue entries are free
// i_rst_n is synchronous, active low, and returns the parser to start of line
`timescale 1ns / 1ps
`default_nettype none

module sse_stream_field_parser_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,    // [7:0] stream_byte
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata,    // [7:0] value_byte, [38:8] retry_delay, [39] zero
    output logic [3:0]  o_m_tuser,    // [1:0] result_kind, [3:2] field_tag
    output logic        o_m_tlast     // last_of_run
);
    import ssefp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_step   w_step;
    t_push   w_push;
    t_result w_res;
    logic    w_room;
    logic    w_accept;

    assign o_s_tready = w_room;
    assign w_accept   = i_s_tvalid && w_room;

    always_comb begin
        w_step  = f_step(r_state, i_s_tdata);
        n_state = w_accept ? w_step.s : r_state;
        w_push  = w_step.push;
        if (!w_accept) begin
            w_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_STATE_RST;
        end else begin
            r_state <= n_state;
        end
    end

    ssefp_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_m_tvalid),
        .i_pop   (i_m_tready),
        .o_res   (w_res)
    );

    assign o_m_tdata = {1'b0, w_res.retry_delay, w_res.value_byte};
    assign o_m_tuser = {w_res.field_tag, w_res.result_kind};
    assign o_m_tlast = w_res.last_of_run;

endmodule

`default_nettype wire

### sim/ssefp_stream_checker.sv
// stream checker for sse_stream_field_parser_core: watches both channels, parses the
// accepted byte stream itself and compares every output transaction in order
// depends on ssefp_pkg for the result kinds, field tags and character codes
`timescale 1ns / 1ps

module ssefp_stream_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [7:0]  i_s_tdata,    // [7:0] stream_byte
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [39:0] i_m_tdata,    // [7:0] value_byte, [38:8] retry_delay, [39] zero
    input  wire  [3:0]  i_m_tuser,    // [1:0] result_kind, [3:2] field_tag
    input  wire         i_m_tlast,    // last_of_run
    output int          o_fail_cnt,
    output int          o_pending
);
    import ssefp_pkg::*;

    typedef enum logic [2:0] {
        LN_START,
        LN_NAME,
        LN_VSTART,
        LN_VALUE,
        LN_SKIP
    } line_phase_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  tag;
        logic [7:0]  vbyte;
        logic [30:0] ms;
        logic        last;
    } sse_result_t;

    localparam logic [34:0] RETRY_LIMIT = 35'd2147483647;

    string field_names [4] = '{"data", "id", "event", "retry"};

    line_phase_e phase;
    logic [3:0]  cand;
    logic [2:0]  nlen;
    logic        cr_pending;
    logic        event_open;
    logic        data_started;
    logic [30:0] retry_val;
    logic        retry_neg;
    logic        retry_digits;
    logic        retry_bad;

    sse_result_t byte_results [$];
    sse_result_t expected_results [$];
    int          fails = 0;

    task automatic start_line();
        phase        = LN_START;
        cand         = 4'hF;
        nlen         = 3'd0;
        cr_pending   = 1'b0;
        retry_val    = 31'd0;
        retry_neg    = 1'b0;
        retry_digits = 1'b0;
        retry_bad    = 1'b0;
    endtask

    task automatic add_result(input logic [1:0] kind, input logic [1:0] tag,
                              input logic [7:0] b, input logic [30:0] ms);
        sse_result_t e;
        e.kind  = kind;
        e.tag   = tag;
        e.vbyte = b;
        e.ms    = ms;
        e.last  = 1'b0;
        byte_results.insert(byte_results.size(), e);
    endtask

    // names still possible whose full length has been seen
    function automatic logic [3:0] complete_names();
        logic [3:0] m;
        m = 4'h0;
        for (int k = 0; k < 4; k++) begin
            if (cand[k] && nlen == field_names[k].len()) begin
                m[k] = 1'b1;
            end
        end
        return m;
    endfunction

    task automatic finish_name(input logic [3:0] m);
        if (m[M_DATA_BIT]) begin
            event_open = 1'b1;
            if (data_started) begin
                add_result(KIND_VALUE, TAG_DATA, CH_LF, 31'd0);
            end
        end else if (m[M_ID_BIT]) begin
            event_open = 1'b1;
            add_result(KIND_CLEAR, TAG_ID, 8'h00, 31'd0);
        end else if (m[M_EVENT_BIT]) begin
            event_open = 1'b1;
            add_result(KIND_CLEAR, TAG_EVENT, 8'h00, 31'd0);
        end
    endtask

    task automatic take_retry_char(input logic [7:0] c);
        logic [34:0] acc;
        acc = '0;
        if (retry_bad) begin
            return;
        end
        if (c == CH_MINUS && !retry_neg && !retry_digits) begin
            retry_neg = 1'b1;
        end else if (c >= CH_0 && c <= CH_9) begin
            acc          = {4'b0, retry_val} * 35'd10 + {31'b0, c[3:0]};
            retry_digits = 1'b1;
            if (acc > RETRY_LIMIT) begin
                retry_bad = 1'b1;
            end else begin
                retry_val = acc[30:0];
            end
        end else begin
            retry_bad = 1'b1;
        end
    endtask

    task automatic take_line_char(input logic [7:0] c);
        logic [3:0] m;
        m = 4'h0;
        if (phase == LN_START) begin
            if (c == CH_COLON) begin
                phase = LN_SKIP;
                return;
            end
            phase = LN_NAME;
        end
        if (phase == LN_NAME) begin
            if (c == CH_COLON) begin
                m    = complete_names();
                cand = m;
                if (m == 4'h0) begin
                    phase = LN_SKIP;
                end else begin
                    phase = LN_VSTART;
                    finish_name(m);
                end
                return;
            end
            for (int k = 0; k < 4; k++) begin
                if (!(nlen < field_names[k].len() && field_names[k][nlen] == c)) begin
                    cand[k] = 1'b0;
                end
            end
            if (nlen != 3'd7) begin
                nlen = nlen + 3'd1;
            end
            return;
        end
        if (phase == LN_VSTART) begin
            phase = LN_VALUE;
            if (c == CH_SPACE) begin
                return;
            end
        end
        if (phase == LN_VALUE) begin
            if (cand[M_RETRY_BIT]) begin
                take_retry_char(c);
            end else if (cand[M_DATA_BIT]) begin
                data_started = 1'b1;
                add_result(KIND_VALUE, TAG_DATA, c, 31'd0);
            end else if (cand[M_ID_BIT]) begin
                add_result(KIND_VALUE, TAG_ID, c, 31'd0);
            end else if (cand[M_EVENT_BIT]) begin
                add_result(KIND_VALUE, TAG_EVENT, c, 31'd0);
            end
        end
    endtask

    task automatic end_of_line();
        case (phase)
            LN_START: begin
                if (event_open) begin
                    add_result(KIND_END, TAG_DATA, 8'h00, 31'd0);
                    event_open   = 1'b0;
                    data_started = 1'b0;
                end
            end
            LN_NAME: begin
                finish_name(complete_names());
            end
            LN_VSTART, LN_VALUE: begin
                if (cand[M_RETRY_BIT] && !retry_bad && retry_digits &&
                    (!retry_neg || retry_val == 31'd0)) begin
                    event_open = 1'b1;
                    add_result(KIND_RETRY, TAG_DATA, 8'h00, retry_val);
                end
            end
            default: begin
            end
        endcase
        start_line();
    endtask

    task automatic parse_stream_byte(input logic [7:0] c);
        sse_result_t e;
        byte_results.delete();
        if (c == CH_LF) begin
            end_of_line();
        end else begin
            if (cr_pending) begin
                cr_pending = 1'b0;
                take_line_char(CH_CR);
            end
            if (c == CH_CR) begin
                if (phase != LN_SKIP) begin
                    cr_pending = 1'b1;
                end
            end else begin
                take_line_char(c);
            end
        end
        for (int k = 0; k < byte_results.size(); k++) begin
            e      = byte_results[k];
            e.last = (k == byte_results.size() - 1);
            expected_results.insert(expected_results.size(), e);
        end
    endtask

    task automatic check_result();
        sse_result_t got;
        sse_result_t want;
        got.kind  = i_m_tuser[1:0];
        got.tag   = i_m_tuser[3:2];
        got.vbyte = i_m_tdata[7:0];
        got.ms    = i_m_tdata[38:8];
        got.last  = i_m_tlast;
        if (expected_results.size() == 0) begin
            if (fails < 10) begin
                $display("%0t: unexpected result kind %0d tag %0d byte %02h ms %0d last %0b",
                         $time, got.kind, got.tag, got.vbyte, got.ms, got.last);
            end
            fails++;
            return;
        end
        want = expected_results.pop_front();
        if (got !== want) begin
            if (fails < 10) begin
                $display("%0t: mismatch, expected kind %0d tag %0d byte %02h ms %0d last %0b",
                         $time, want.kind, want.tag, want.vbyte, want.ms, want.last);
                $display("%0t:           actual   kind %0d tag %0d byte %02h ms %0d last %0b",
                         $time, got.kind, got.tag, got.vbyte, got.ms, got.last);
            end
            fails++;
        end
    endtask

    // input side first; a result is registered in the dut queue before it leaves
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_line();
            event_open   = 1'b0;
            data_started = 1'b0;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                parse_stream_byte(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_result();
            end
        end
        o_fail_cnt <= fails;
        o_pending  <= expected_results.size();
    end

endmodule

### sim/tb_sse_stream_field_parser_core.sv
// testbench top for sse_stream_field_parser_core: clock, reset, byte stream stimulus
// with bursty input and stalling output, watchdog and verdict
// depends on ssefp_pkg, sse_stream_field_parser_core and ssefp_stream_checker
`timescale 1ns / 1ps

module tb_sse_stream_field_parser_core;
    import ssefp_pkg::*;

    localparam int RANDOM_BYTES   = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 120;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } rx_mode_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    int          fail_cnt;
    int          pending;

    logic [7:0]  stream_q [$];
    int          bytes_sent = 0;
    int          burst_left = 0;
    bit          long_hold_req = 1'b0;

    sse_stream_field_parser_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    ssefp_stream_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        forever begin
            #4 clk = ~clk;
        end
    end

    task automatic add_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), b);
    endtask

    task automatic push_text(input string t);
        for (int k = 0; k < t.len(); k++) begin
            add_byte(t[k]);
        end
    endtask

    task automatic push_eol();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            add_byte(CH_LF);
        end else if (r < 19) begin
            add_byte(CH_CR);
            add_byte(CH_LF);
        end else begin
            // lone cr, spills into the next line
            add_byte(CH_CR);
        end
    endtask

    function automatic logic [7:0] rand_value_byte();
        logic [7:0] b;
        int         r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            b = 8'($urandom_range(8'h20, 8'h7E));
        end else if (r == 6) begin
            b = CH_CR;
        end else begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_LF) begin
                b = CH_CR;
            end
        end
        return b;
    endfunction

    task automatic push_value();
        int n;
        n = $urandom_range(0, 8);
        if ($urandom_range(0, 1) == 1) begin
            add_byte(CH_SPACE);
        end
        repeat (n) add_byte(rand_value_byte());
    endtask

    task automatic push_retry_value();
        string digits;
        digits = $sformatf("%0d", $urandom_range(0, 99999));
        if ($urandom_range(0, 1) == 1) begin
            push_text(" ");
        end
        case ($urandom_range(0, 10))
            0:       push_text($sformatf("%0d", $urandom_range(0, 9)));
            1, 2:    push_text($sformatf("%0d", $urandom & 32'h7FFF_FFFF));
            3:       push_text("2147483647");
            4:       push_text("2147483648");
            5:       push_text("-0");
            6:       push_text({"-", digits});
            7:       push_text({digits, "x"});
            8:       push_text("");
            9:       push_text("99999999999");
            default: push_text({"-", "-", digits});
        endcase
    endtask

    task automatic make_random_line();
        string letters;
        int    sel;
        int    n;
        letters = "adeinrtvy";
        sel     = $urandom_range(0, 99);
        if (sel < 30) begin
            push_text("data:");
            push_value();
        end else if (sel < 42) begin
            push_text("id:");
            push_value();
        end else if (sel < 54) begin
            push_text("event:");
            push_value();
        end else if (sel < 68) begin
            push_text("retry:");
            push_retry_value();
        end else if (sel < 74) begin
            push_text(":");
            push_value();
        end else if (sel < 80) begin
            n = $urandom_range(1, 8);
            repeat (n) add_byte(letters[$urandom_range(0, 8)]);
            if ($urandom_range(0, 3) != 0) begin
                push_text(":");
                push_value();
            end
        end else if (sel < 85) begin
            case ($urandom_range(0, 3))
                0:       push_text("data");
                1:       push_text("id");
                2:       push_text("event");
                default: push_text("retry");
            endcase
        end else if (sel < 96) begin
            // blank line
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
        end
        push_eol();
    endtask

    task automatic idle_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_queued();
        while (stream_q.size() != 0) begin
            send_byte(stream_q.pop_front());
        end
    endtask

    task automatic wait_drained();
        idle_input();
        while (pending != 0) @(posedge clk);
    endtask

    // output side stall pattern
    initial begin
        rx_mode_e mode;
        int       mode_left;
        int       hold_left;
        int       cyc;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        cyc       = 0;
        forever begin
            @(negedge clk);
            cyc++;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                    default:     m_tready <= (cyc % 4 != 3);
                endcase
            end
        end
    end

    // cycles without any transaction
    initial begin
        int idle;
        idle = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
            if (idle >= WATCHDOG_LIMIT) begin
                $display("** sse_stream_field_parser_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // id clear, event end, trimmed data with extreme bytes and a cr held
        // before a non-lf byte, data line without colon, retry of minus zero,
        // blank line, comment ended by cr lf
        push_text("id:\n\n");
        push_text("data: ");
        add_byte(8'hFF);
        add_byte(CH_CR);
        add_byte(8'h00);
        push_text("\ndata\nretry:-0\n\n:\r\n");
        send_queued();
        wait_drained();

        long_hold_req = 1'b1;
        while (bytes_sent < RANDOM_BYTES / 2) begin
            make_random_line();
            send_queued();
        end
        wait_drained();
        while (bytes_sent < RANDOM_BYTES + 30) begin
            make_random_line();
            send_queued();
        end
        push_text("\n\n");
        send_queued();
        wait_drained();
        repeat (16) @(posedge clk);

        if (fail_cnt == 0 && pending == 0) begin
            $display("** sse_stream_field_parser_core: PASSED **");
        end else begin
            $display("** sse_stream_field_parser_core: FAILED **");
        end
        $finish;
    end

endmodule

### sse_stream_field_parser_core.f
hdl/ssefp_pkg.sv
hdl/ssefp_res_queue.sv
hdl/sse_stream_field_parser_core.sv
sim/ssefp_stream_checker.sv
sim/tb_sse_stream_field_parser_core.sv
